/* src/cbd_pkg.sv */
// Shared types and constants of the cross blur / decimate block.
// No dependencies; every other file of the block imports this package.
package cbd_pkg;

    localparam int MAX_WIDTH_DEF = 4096;   // default line store depth
    localparam int CHAN_W        = 8;      // one color channel
    localparam int RGB_W         = 3 * CHAN_W;
    localparam int CFG_W         = 13;     // width / height register width
    localparam int ROW_W         = 13;     // input row counter
    localparam int OROW_W        = 10;     // downscaled row
    localparam int OCOL_W        = 10;     // downscaled column
    localparam int HEIGHT_LIMIT  = 4096;   // largest usable frame height
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd3840;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd2160;

    // operation field codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_rgb;

    // the five taps of the cross
    typedef struct packed {
        t_rgb mid;
        t_rgb up;
        t_rgb down;
        t_rgb left;
        t_rgb right;
    } t_nbr;

    // one result word
    typedef struct packed {
        logic [OROW_W-1:0] row;
        logic [OCOL_W-1:0] col;
        t_rgb              pix;
    } t_res;

endpackage

/* src/cbd_if.sv */
// Valid/ready channel interfaces: pixel input, result output, config writes.
// Depends on cbd_pkg for field widths and the register index type.
interface cbd_pix_if import cbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              operation;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] red_in;

    modport source (output valid, operation, blue_in, green_in, red_in, input ready);
    modport sink   (input valid, operation, blue_in, green_in, red_in, output ready);
endinterface

interface cbd_res_if import cbd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OROW_W-1:0] out_row;
    logic [OCOL_W-1:0] out_col;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;

    modport source (output valid, out_row, out_col, blue_out, green_out, red_out,
                    input ready);
    modport sink   (input valid, out_row, out_col, blue_out, green_out, red_out,
                    output ready);
endinterface

interface cbd_cfg_if import cbd_pkg::*; ();
    logic             valid;
    logic             ready;
    t_cfg_idx         index;
    logic [CFG_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/cbd_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// Read during write to the same address returns the old data.
module cbd_ram import cbd_pkg::*; #(
    parameter int  WIDTH  = RGB_W,
    parameter int  DEPTH  = MAX_WIDTH_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* src/cbd_blur.sv */
// Five-tap cross average per channel, truncating divide by 5.
// Depends on cbd_pkg (t_nbr, t_rgb).
module cbd_blur import cbd_pkg::*; (
    input  t_nbr i_nbr,
    output t_rgb o_avg
);

    localparam int SUM_W    = CHAN_W + 3;          // 5 * 255 fits
    localparam int DIV5_SH  = 13;
    localparam int DIV5_MUL = 1639;                // ceil(2^13 / 5), exact below 2730
    localparam int PROD_W   = SUM_W + DIV5_SH;

    function automatic logic [CHAN_W-1:0] avg5(
        input logic [CHAN_W-1:0] a,
        input logic [CHAN_W-1:0] b,
        input logic [CHAN_W-1:0] c,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] e
    );
        logic [SUM_W-1:0]  s;
        logic [PROD_W-1:0] p;
        s = SUM_W'(a) + SUM_W'(b) + SUM_W'(c) + SUM_W'(d) + SUM_W'(e);
        p = PROD_W'(s) * PROD_W'(DIV5_MUL);
        return p[DIV5_SH +: CHAN_W];
    endfunction

    assign o_avg.red   = avg5(i_nbr.mid.red, i_nbr.up.red, i_nbr.down.red,
                              i_nbr.left.red, i_nbr.right.red);
    assign o_avg.green = avg5(i_nbr.mid.green, i_nbr.up.green, i_nbr.down.green,
                              i_nbr.left.green, i_nbr.right.green);
    assign o_avg.blue  = avg5(i_nbr.mid.blue, i_nbr.up.blue, i_nbr.down.blue,
                              i_nbr.left.blue, i_nbr.right.blue);

endmodule

/* src/cbd_outq.sv */
// Two-entry result queue between the blur stage and the output channel.
// Depends on cbd_pkg (t_res).
module cbd_outq import cbd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_res       i_data,
    input  logic       i_pop,
    output logic       o_valid,
    output t_res       o_data,
    output logic [1:0] o_count
);

    t_res       r_slot [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_data;
        end
    end

    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_slot[r_rptr];
    assign o_count = r_count;

endmodule

/* src/cross_blur_decimate.sv */
// Cross blur with sparse 2/9 x 1/6 downscale. Pixels enter in raster order, one word per
// clock; a steady stream runs at one pixel per clock with no bubbles while the output
// side accepts. Each pixel is averaged with its up/down/left/right neighbours (edges
// repeat, divide by 5 truncates), and the blurred pixel of row r leaves while row r+1
// arrives, so after the last row the user sends one flush word per column. Only pixels
// whose row and column are both even or both odd produce a result word; results landing
// outside the downscaled image are dropped. Throughput is set by the two line stores,
// each a single-port-read/single-port-write RAM touched once per pixel, plus a two-entry
// result queue that lets input go on while the output stalls, until it and the blur
// stage hold two words. The line stores need no clearing after reset; reading a location
// never written (flush on the very first row) gives undefined pixel data. The user makes
// width/height writes only while the block is idle (the block does not enforce this); they
// apply to the next pixel. Depends on cbd_pkg, cbd_if, cbd_ram, cbd_blur, cbd_outq.
module cross_blur_decimate import cbd_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cbd_pix_if.sink   i_pix,
    cbd_res_if.source o_res,
    cbd_cfg_if.sink   i_cfg
);

    localparam int AW        = $clog2(MAX_WIDTH);   // column address
    localparam int WW        = AW + 1;              // holds the width itself
    localparam int DIV_SH    = 16;
    localparam int DIV9_MUL  = 7282;                // ceil(2^16/9), exact below 32768
    localparam int DIV6_MUL  = 10923;               // ceil(2^16/6), exact below 32768

    // ---------------- configuration ----------------
    logic             cfg_acc;
    logic [CFG_W-1:0] r_cfg_width;
    logic [CFG_W-1:0] r_cfg_height;

    assign i_cfg.ready = i_rst_n;
    assign cfg_acc     = i_cfg.valid && i_cfg.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= WIDTH_RST;
            r_cfg_height <= HEIGHT_RST;
        end else if (cfg_acc) begin
            case (i_cfg.index)
                CFG_FRAME_WIDTH:  r_cfg_width  <= i_cfg.data;
                CFG_FRAME_HEIGHT: r_cfg_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // clamp to the usable range
    logic [WW-1:0]    eff_w;
    logic [ROW_W-1:0] eff_h;

    always_comb begin
        if (r_cfg_width == '0) begin
            eff_w = WW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(r_cfg_width);
        end
        if (r_cfg_height == '0) begin
            eff_h = ROW_W'(1);
        end else if (32'(r_cfg_height) > HEIGHT_LIMIT) begin
            eff_h = ROW_W'(HEIGHT_LIMIT);
        end else begin
            eff_h = ROW_W'(r_cfg_height);
        end
    end

    // output image size, refreshed every clock (the user keeps config static while busy; not enforced)
    logic [31:0]       wlim_prod;
    logic [31:0]       hlim_prod;
    logic [AW-1:0]     r_wlim;    // width / 6
    logic [OROW_W-1:0] r_hlim;    // height * 2 / 9

    assign wlim_prod = 32'(eff_w) * 32'(DIV6_MUL);
    assign hlim_prod = 32'({eff_h, 1'b0}) * 32'(DIV9_MUL);

    always_ff @(posedge i_clk) begin
        r_wlim <= wlim_prod[DIV_SH +: AW];
        r_hlim <= hlim_prod[DIV_SH +: OROW_W];
    end

    // ---------------- handshake / queue status ----------------
    logic       pix_acc;
    logic       q_push;
    logic       q_pop;
    logic       q_valid;
    logic [1:0] q_count;
    logic [2:0] occ;
    t_res       q_data;
    t_res       res;
    logic       r_s1_valid;

    // room check counts the word in the blur stage and the queue, minus a pop now
    assign occ          = {1'b0, q_count} + 3'(r_s1_valid) - 3'(q_pop);
    assign i_pix.ready  = i_rst_n && (occ < 3'd2);
    assign pix_acc      = i_pix.valid && i_pix.ready;

    // ---------------- stage 0: position, line store reads ----------------
    logic [AW-1:0]    r_col;
    logic [ROW_W-1:0] r_row;
    logic [AW-1:0]    n_col;
    logic [ROW_W-1:0] n_row;
    logic [WW-1:0]    col_ext;
    logic             col_last;
    logic [AW-1:0]    col_ahead;

    assign col_ext   = WW'(r_col) + WW'(1);
    assign col_last  = (col_ext >= eff_w);
    assign col_ahead = r_col + AW'(1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (pix_acc) begin
            if (col_last) begin
                n_col = '0;
                n_row = (r_row >= eff_h) ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = col_ahead;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // the blurred pixel is for row r-1, column c
    logic [ROW_W-1:0]  row_i;
    logic [ROW_W-1:0]  row_dbl;
    logic [31:0]       orow_prod;
    logic [31:0]       ocol_prod;
    logic              pos_ok;
    logic [OROW_W-1:0] s0_orow;
    logic [AW-1:0]     s0_ocol;

    assign row_i     = r_row - ROW_W'(1);
    assign row_dbl   = {row_i[ROW_W-2:0], 1'b0};
    assign orow_prod = 32'(row_dbl) * 32'(DIV9_MUL);
    assign ocol_prod = 32'(r_col) * 32'(DIV6_MUL);
    // odd/odd lands one row and one column further
    assign s0_orow   = orow_prod[DIV_SH +: OROW_W] + OROW_W'(row_i[0]);
    assign s0_ocol   = ocol_prod[DIV_SH +: AW] + AW'(row_i[0]);
    assign pos_ok    = (r_row != '0) && (r_row <= eff_h) && (row_i[0] == r_col[0]);

    // ---------------- stage 1 registers ----------------
    logic [AW-1:0]     r_s1_col;
    logic              r_s1_first;
    logic              r_s1_has_right;
    logic              r_s1_has_up;
    logic              r_s1_pos_ok;
    logic [OROW_W-1:0] r_s1_orow;
    logic [AW-1:0]     r_s1_ocol;
    logic              r_s1_flush;
    t_rgb              r_s1_pix;
    logic              r_s1_fwd_old;
    logic              r_s1_fwd_new;

    // same-entry hazards against the write of the word now in stage 1
    logic fwd_old;
    logic fwd_new;

    assign fwd_old = r_s1_valid && (r_s1_col == r_col);
    assign fwd_new = r_s1_valid && (r_s1_col == col_ahead);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= pix_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_col       <= r_col;
            r_s1_first     <= (r_col == '0);
            r_s1_has_right <= !col_last;
            r_s1_has_up    <= (r_row >= ROW_W'(2));
            r_s1_pos_ok    <= pos_ok;
            r_s1_orow      <= s0_orow;
            r_s1_ocol      <= s0_ocol;
            r_s1_flush     <= (i_pix.operation == OP_FLUSH);
            r_s1_pix.red   <= i_pix.red_in;
            r_s1_pix.green <= i_pix.green_in;
            r_s1_pix.blue  <= i_pix.blue_in;
            r_s1_fwd_old   <= fwd_old;
            r_s1_fwd_new   <= fwd_new;
        end
    end

    // ---------------- line stores ----------------
    // older: row above the newer row; newer: most recent row
    t_rgb older_rdata;
    t_rgb newer_rdata;
    t_nbr nbr;

    cbd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_older (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (nbr.mid),
        .i_raddr (r_col),
        .o_rdata (older_rdata)
    );

    cbd_ram #(
        .WIDTH (RGB_W),
        .DEPTH (MAX_WIDTH)
    ) u_newer (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (nbr.down),
        .i_raddr (col_ahead),
        .o_rdata (newer_rdata)
    );

    // ---------------- stage 1: assemble the cross, write back ----------------
    // r_ahead:     newer[c] fetched as the right tap of the previous word
    // r_new0:      newer[0], the first pixel of the latest row
    // r_prev_mid:  previous word's center, i.e. older[c-1]
    // r_last_down: previous word's newer write, forwarded on a same-entry read
    t_rgb r_ahead;
    t_rgb r_new0;
    t_rgb r_prev_mid;
    t_rgb r_last_down;
    t_rgb up_raw;
    t_rgb right_raw;

    assign up_raw    = r_s1_fwd_old ? r_prev_mid  : older_rdata;
    assign right_raw = r_s1_fwd_new ? r_last_down : newer_rdata;

    always_comb begin
        nbr.mid   = r_s1_first ? r_new0 : r_ahead;
        nbr.up    = r_s1_has_up ? up_raw : nbr.mid;
        nbr.left  = r_s1_first ? nbr.mid : r_prev_mid;
        nbr.right = r_s1_has_right ? right_raw : nbr.mid;
        // a flush word stands for a copy of the pixel above it
        nbr.down  = r_s1_flush ? nbr.mid : r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_ahead     <= right_raw;
            r_prev_mid  <= nbr.mid;
            r_last_down <= nbr.down;
            if (r_s1_first) begin
                r_new0 <= nbr.down;
            end
        end
    end

    t_rgb avg;

    cbd_blur u_blur (
        .i_nbr (nbr),
        .o_avg (avg)
    );

    // drop writes outside the downscaled image
    assign q_push  = r_s1_valid && r_s1_pos_ok && (r_s1_orow < r_hlim)
                     && (r_s1_ocol < r_wlim);
    assign res.row = r_s1_orow;
    assign res.col = OCOL_W'(r_s1_ocol);
    assign res.pix = avg;

    // ---------------- result queue / output ----------------
    assign q_pop = q_valid && o_res.ready;

    cbd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (res),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (q_data),
        .o_count (q_count)
    );

    assign o_res.valid     = q_valid;
    assign o_res.out_row   = q_data.row;
    assign o_res.out_col   = q_data.col;
    assign o_res.blue_out  = q_data.pix.blue;
    assign o_res.green_out = q_data.pix.green;
    assign o_res.red_out   = q_data.pix.red;

    // ---------------- assertions ----------------
    a_q_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> (q_count != 2'd2 || q_pop))
        else $error("result queue overflow");

    a_q_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |=> q_valid)
        else $error("pushed result word not offered");

    a_push_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> $past(pix_acc))
        else $error("result word without an input word one clock earlier");

endmodule

/* tb/sv/tb_cross_blur_decimate.sv */
// Self-checking bench for cross_blur_decimate: directed frame, then random frames.
// Depends on cbd_pkg and the cbd_pix_if / cbd_res_if / cbd_cfg_if interfaces.
module tb_cross_blur_decimate import cbd_pkg::*; ();

    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;     // output back-pressure long enough to fill the block
    localparam int LIMIT_CYCLES  = 500_000;

    logic i_clk;
    logic i_rst_n = 1'b0;

    cbd_pix_if pix_if ();
    cbd_res_if res_if ();
    cbd_cfg_if cfg_if ();

    cross_blur_decimate #(.MAX_WIDTH(MAX_W)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow of the block: registers, line stores and raster position.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_reg  = WIDTH_RST;
    logic [CFG_W-1:0] height_reg = HEIGHT_RST;
    t_rgb             older_line [MAX_W];
    t_rgb             newer_line [MAX_W];
    bit               newer_def  [MAX_W];  // entry holds real pixel data
    int               cur_col = 0;
    int               cur_row = 0;

    t_res pending_writes [$];              // downscaled writes not yet seen on the output
    int   mismatch_count = 0;

    // sender / receiver pacing
    int        burst_left    = 0;
    int        gap_max_cur   = 3;
    int        hold_requests = 0;
    int        holds_served  = 0;
    int        hold_left     = 0;
    int        pat_age       = 0;
    bit [15:0] stall_pat     = '1;

    function automatic int eff_w();
        if (width_reg == 0) return 1;
        if (width_reg > MAX_W) return MAX_W;
        return int'(width_reg);
    endfunction

    function automatic int eff_h();
        if (height_reg == 0) return 1;
        if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
        return int'(height_reg);
    endfunction

    function automatic logic [CHAN_W-1:0] avg5(input logic [CHAN_W-1:0] a, b, c, d, e);
        int s;
        s = a + b + c + d + e;
        return CHAN_W'(s / 5);
    endfunction

    // Blur the pixel one row up at the current column, place it in the
    // downscaled grid, then advance the line stores and raster position.
    // Returns 1 when a write lands inside the output image.
    function automatic bit blur_and_place(input logic op, input t_rgb px, output t_res wr);
        int   w, h, c, r, i, orow, ocol;
        t_rgb mid, up, down, nb_left, nb_right;
        bit   hit;
        w   = eff_w();
        h   = eff_h();
        c   = cur_col;
        r   = cur_row;
        hit = 1'b0;
        wr  = '0;

        mid      = newer_line[c];
        up       = (r >= 2) ? older_line[c] : mid;
        nb_left  = (c > 0) ? older_line[c-1] : mid;    // already rotated into the older row
        nb_right = (c + 1 < w) ? newer_line[c+1] : mid;
        down     = (op == OP_FLUSH) ? mid : px;        // flush repeats the bottom edge

        if (r >= 1 && r - 1 < h) begin
            i = r - 1;
            if (((i + c) % 2) == 0) begin
                orow = (i * 2) / 9;
                ocol = c / 6;
                if (i % 2 == 1) begin                  // odd/odd lands one down, one right
                    orow++;
                    ocol++;
                end
                if (orow < (h * 2) / 9 && ocol < w / 6) begin
                    hit           = 1'b1;
                    wr.row        = OROW_W'(orow);
                    wr.col        = OCOL_W'(ocol);
                    wr.pix.red    = avg5(mid.red, up.red, down.red, nb_left.red, nb_right.red);
                    wr.pix.green  = avg5(mid.green, up.green, down.green,
                                         nb_left.green, nb_right.green);
                    wr.pix.blue   = avg5(mid.blue, up.blue, down.blue,
                                         nb_left.blue, nb_right.blue);
                end
            end
        end

        older_line[c] = mid;
        newer_line[c] = down;
        if (op == OP_PIXEL) newer_def[c] = 1'b1;

        if (c + 1 >= w) begin
            cur_col = 0;
            cur_row = (r >= h) ? 0 : r + 1;
        end else begin
            cur_col = c + 1;
        end
        return hit;
    endfunction

    // ------------------------------------------------------------------
    // Directed frame: 6 x 5, rows 0..3. Extremes of every channel, both
    // operations, a mid-frame flush row and dropped odd/odd writes.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic             is_cfg;
        t_cfg_idx         reg_sel;
        logic [CFG_W-1:0] reg_val;
        logic             op;
        t_rgb             px;
        logic             typed;
        t_res             want;
    } t_dir_row;

    localparam t_rgb BLACK   = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    localparam t_rgb WHITE   = '{red: 8'd255, green: 8'd255, blue: 8'd255};
    localparam t_rgb MAGENTA = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
    localparam t_rgb GREEN   = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
    localparam t_res NO_WR   = '0;
    // magenta row blurred with a green row below: 4*255/5 and 255/5
    localparam t_res WR_A    = '{row: 10'd0, col: 10'd0,
                                 pix: '{red: 8'd204, green: 8'd51, blue: 8'd204}};

    localparam int DIR_ROWS = 26;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        '{1'b1, CFG_FRAME_WIDTH,  13'd6, OP_PIXEL, BLACK,   1'b0, NO_WR},
        '{1'b1, CFG_FRAME_HEIGHT, 13'd5, OP_PIXEL, BLACK,   1'b0, NO_WR},
        // row 0: nothing comes out yet
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, MAGENTA, 1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, MAGENTA, 1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, MAGENTA, 1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, MAGENTA, 1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, MAGENTA, 1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, MAGENTA, 1'b0, NO_WR},
        // row 1: even columns of row 0 all land at (0,0)
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, GREEN,   1'b1, WR_A},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, GREEN,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, GREEN,   1'b1, WR_A},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, GREEN,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, GREEN,   1'b1, WR_A},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, GREEN,   1'b0, NO_WR},
        // row 2: flush inside the frame; odd/odd writes fall off the grid
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_FLUSH, WHITE,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_FLUSH, WHITE,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_FLUSH, WHITE,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_FLUSH, WHITE,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_FLUSH, WHITE,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_FLUSH, WHITE,   1'b0, NO_WR},
        // row 3: blurs row 2, checked by the shadow model
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, WHITE,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, BLACK,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, WHITE,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, BLACK,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, WHITE,   1'b0, NO_WR},
        '{1'b0, CFG_FRAME_WIDTH,  13'd0, OP_PIXEL, BLACK,   1'b0, NO_WR}
    };

    // ------------------------------------------------------------------
    // Pixel side. Called at a falling edge, returns at a falling edge.
    // Bursts of random length, random gaps in between.
    // ------------------------------------------------------------------
    task automatic push_word(input logic op, input t_rgb px, input bit typed,
                             input t_res want);
        int   gap;
        t_res wr;
        bit   hit;
        if (burst_left == 0) begin
            gap = (gap_max_cur == 0) ? 0 : $urandom_range(0, gap_max_cur);
            if (gap > 0) begin
                pix_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 32);
        end
        pix_if.valid     <= 1'b1;
        pix_if.operation <= op;
        pix_if.red_in    <= px.red;
        pix_if.green_in  <= px.green;
        pix_if.blue_in   <= px.blue;
        do @(posedge i_clk); while (!pix_if.ready);
        hit = blur_and_place(op, px, wr);
        if (typed)    pending_writes.push_back(want);
        else if (hit) pending_writes.push_back(wr);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Mostly well-formed frames: flushes on the flush row, pixels elsewhere,
    // with a few flushes mid-frame and pixels where a flush belongs.
    // A flush on row 0 only where the line store already holds real data.
    task automatic push_random();
        logic op;
        t_rgb px;
        op = OP_PIXEL;
        if (cur_row >= eff_h()) begin
            if ($urandom_range(0, 9) != 0) op = OP_FLUSH;
        end else if (cur_row != 0 || newer_def[cur_col]) begin
            if ($urandom_range(0, 19) == 0) op = OP_FLUSH;
        end
        case ($urandom_range(0, 7))
            0:       px = '0;
            1:       px = '1;
            default: px = 24'($urandom);
        endcase
        push_word(op, px, 1'b0, NO_WR);
    endtask

    task automatic feed_frames(input int n);
        repeat (n) begin
            do push_random(); while (cur_col != 0 || cur_row != 0);
        end
    endtask

    // Stop offering, wait for every write, then let words that make no
    // write clear the pipeline.
    task automatic drain_and_settle();
        pix_if.valid <= 1'b0;
        burst_left = 0;
        while (pending_writes.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx sel, input logic [CFG_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= sel;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
        if (sel == CFG_FRAME_WIDTH) width_reg = val;
        else                        height_reg = val;
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input int frames, input int gaps, input bit long_hold);
        drain_and_settle();
        write_reg(CFG_FRAME_WIDTH, w);
        write_reg(CFG_FRAME_HEIGHT, h);
        gap_max_cur = gaps;
        if (long_hold) hold_requests++;
        feed_frames(frames);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        for (int k = 0; k < MAX_W; k++) begin
            older_line[k] = '0;
            newer_line[k] = '0;
            newer_def[k]  = 1'b0;
        end
        pix_if.valid     = 1'b0;
        pix_if.operation = OP_PIXEL;
        pix_if.red_in    = '0;
        pix_if.green_in  = '0;
        pix_if.blue_in   = '0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = CFG_FRAME_WIDTH;
        cfg_if.data      = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < DIR_ROWS; k++) begin
            if (DIR_TABLE[k].is_cfg) begin
                drain_and_settle();
                write_reg(DIR_TABLE[k].reg_sel, DIR_TABLE[k].reg_val);
            end else begin
                push_word(DIR_TABLE[k].op, DIR_TABLE[k].px, DIR_TABLE[k].typed,
                          DIR_TABLE[k].want);
            end
        end
        // finish the directed frame, including its flush row
        while (cur_col != 0 || cur_row != 0) push_random();

        // dense writes with no sender gaps while the receiver holds off
        run_phase(13'd12, 13'd9, 2, 0, 1'b1);
        // both registers at zero: 1 x 1 frames, never a write
        run_phase(13'd0, 13'd0, 10, 3, 1'b0);
        // smallest frame that still makes writes
        run_phase(13'd6, 13'd5, 3, 6, 1'b0);

        // Oversize registers clamp to the line store depth and the height limit; then both
        // shrink mid-frame: the row ends on the next word, the frame at the end of row 3.
        run_phase(13'd8191, 13'd8191, 0, 2, 1'b0);
        repeat (30) push_random();
        drain_and_settle();
        write_reg(CFG_FRAME_WIDTH, 13'd7);
        do push_random(); while (cur_row != 3 || cur_col != 0);
        drain_and_settle();
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        while (cur_col != 0 || cur_row != 0) push_random();

        run_phase(13'd24, 13'd14, 1, 2, 1'b0);
        run_phase(13'd17, 13'd11, 1, 4, 1'b0);

        drain_and_settle();
        if (mismatch_count == 0 && pending_writes.size() == 0) begin
            $display("** cross_blur_decimate: PASSED **");
        end else begin
            $display("** cross_blur_decimate: FAILED **");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: stall pattern re-drawn at random intervals, plus a
    // long hold-off when the stimulus asks for one.
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
            res_if.ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served = holds_served + 1;
            hold_left    = LONG_HOLD;
            res_if.ready <= 1'b0;
        end else begin
            if (pat_age == 0) begin
                case ($urandom_range(0, 3))
                    0:       stall_pat = '1;
                    1:       stall_pat = 16'($urandom);
                    2:       stall_pat = 16'($urandom) | 16'($urandom);
                    default: stall_pat = (16'($urandom) & 16'($urandom)) | 16'h8001;
                endcase
                pat_age = $urandom_range(16, 64);
            end
            pat_age = pat_age - 1;
            res_if.ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[15:1]};
        end
    end

    function automatic void check_field(input string name, input logic [9:0] want,
                                        input logic [9:0] got);
        if (got !== want) begin
            $display("%0t %s mismatch: expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_res want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t unexpected write: expected none, got (%0d,%0d) rgb %0d/%0d/%0d",
                         $time, res_if.out_row, res_if.out_col, res_if.red_out,
                         res_if.green_out, res_if.blue_out);
                mismatch_count++;
            end else begin
                want = pending_writes.pop_front();
                check_field("out_row",   want.row,       res_if.out_row);
                check_field("out_col",   want.col,       res_if.out_col);
                check_field("blue_out",  10'(want.pix.blue),  10'(res_if.blue_out));
                check_field("green_out", 10'(want.pix.green), 10'(res_if.green_out));
                check_field("red_out",   10'(want.pix.red),   10'(res_if.red_out));
            end
        end
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 12);
        $display("** cross_blur_decimate: FAILED **");
        $finish;
    end

endmodule
